>>> hdl/dirty_bitmap_with_page_queue_macros.svh
// Assertion macros shared by the dirty bitmap block.
`ifndef DIRTY_BITMAP_WITH_PAGE_QUEUE_MACROS_SVH
`define DIRTY_BITMAP_WITH_PAGE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dirty bitmap check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DBPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dirty bitmap check failed");

`endif

>>> hdl/dbpq_pkg.sv
// Shared types and constants of the dirty bitmap with page queue.
package dbpq_pkg;

    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 18;
    localparam int LIMIT_W    = 19;
    localparam int POPPED_W   = 6;
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'd262144;

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

>>> hdl/dirty_bitmap_with_page_queue.sv
// Top level of the dirty block bitmap with its queue of dirty pages.
`include "dirty_bitmap_with_page_queue_macros.svh"

// Dirty block bitmap with a queue of dirty pages. The bitmap holds
// PAGE_BITS * NUM_PAGES bits, kept as 64-bit words in one RAM, and is split
// into pages of PAGE_BITS bits (PAGE_BITS must be a power of two). A set request
// sets a clear bit and a clear request clears a set bit; either change marks the
// bit's page dirty and, if the page was not already marked, pushes it onto the
// page queue. A pop request takes the oldest dirty page off the queue and clears
// its mark. Every request returns exactly one result carrying the running count
// of set bits. Set and clear requests whose index is at or beyond bit_limit (or
// beyond the bitmap) are flagged out_of_range and change nothing. After reset
// the block sweeps the bitmap and mark RAMs to zero, one word per cycle, over
// PAGE_BITS * NUM_PAGES / 64 words (4096 with the defaults); s_ready stays low
// during that sweep, while configuration writes are taken as usual. After that,
// a request is accepted in ST_IDLE, which reads the bitmap word, page mark and
// queue head from their RAMs; ST_EXEC then, once the result register is free,
// modifies and writes them back and loads the result register. The next request
// is taken in the cycle after the result is loaded, even if that result has not yet been taken.
module dirty_bitmap_with_page_queue #(
    parameter int PAGE_BITS = 4096,
    parameter int NUM_PAGES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: bit_limit.
    input  logic                           cfg_wr_en,
    input  logic [dbpq_pkg::LIMIT_W-1:0]   cfg_wr_data,
    // Request channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dbpq_pkg::CMD_W-1:0]     s_command,
    input  logic [dbpq_pkg::INDEX_W-1:0]   s_bit_index,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_changed,
    output logic                           m_out_of_range,
    output logic                           m_pop_valid,
    output logic [dbpq_pkg::POPPED_W-1:0]  m_popped_page,
    output logic [dbpq_pkg::LIMIT_W-1:0]   m_set_count
);

    import dbpq_pkg::*;

    localparam int unsigned MAP_BITS   = PAGE_BITS * NUM_PAGES;
    localparam int unsigned WORD_COUNT = MAP_BITS / WORD_BITS;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PAGE_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FILL_W     = $clog2(NUM_PAGES + 1);
    localparam int PAGE_LOG2  = $clog2(PAGE_BITS);

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);
    localparam logic [PAGE_W-1:0]  LAST_SLOT = PAGE_W'(NUM_PAGES - 1);
    localparam logic [FILL_W-1:0]  FILL_MAX  = FILL_W'(NUM_PAGES);

    // Control state.
    state_t              state_reg, state_next;
    logic [WORD_AW-1:0]  clr_idx_reg, clr_idx_next;
    logic [PAGE_W-1:0]   head_reg, head_next;
    logic [PAGE_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [LIMIT_W-1:0]  count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                m_valid_reg, m_valid_next;

    // Request held while its RAM reads are in flight.
    logic [CMD_W-1:0]    cmd_reg;
    logic                oor_reg;
    logic [WORD_AW-1:0]  word_addr_reg;
    logic [WORD_SHIFT-1:0] bit_lo_reg;
    logic [PAGE_W-1:0]   page_reg;

    // Result register.
    logic                changed_reg;
    logic                oor_out_reg;
    logic                pop_valid_reg;
    logic [POPPED_W-1:0] popped_reg;

    // FSM outputs.
    logic accept;
    logic clearing;
    logic exec_active;
    logic fire;

    // Incoming request decode.
    logic [31:0]         idx32;
    logic [31:0]         idx_word;
    logic [31:0]         idx_page;
    logic                in_oor;

    // RAM ports.
    logic                bm_wr_en;
    logic [WORD_AW-1:0]  bm_wr_addr;
    logic [WORD_BITS-1:0] bm_wr_data;
    logic [WORD_BITS-1:0] bm_rd_data;
    logic                mk_wr_en;
    logic [PAGE_W-1:0]   mk_wr_addr;
    logic [0:0]          mk_wr_data;
    logic [0:0]          mk_rd_data;
    logic                fq_wr_en;
    logic [PAGE_W-1:0]   fq_rd_data;

    // Execute-stage decode.
    logic                is_set;
    logic                changed;
    logic                enqueue;
    logic                pop_ok;
    logic [WORD_BITS-1:0] bit_mask;

    assign idx32    = 32'(s_bit_index);
    assign idx_word = idx32 >> WORD_SHIFT;
    assign idx_page = idx32 >> PAGE_LOG2;
    assign in_oor   = (idx32 >= 32'(limit_reg)) || (idx32 >= MAP_BITS);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // FSM outputs.
    always_comb begin
        s_ready     = 1'b0;
        clearing    = 1'b0;
        exec_active = 1'b0;
        case (state_reg)
            ST_CLEAR: clearing    = 1'b1;
            ST_IDLE:  s_ready     = 1'b1;
            ST_EXEC:  exec_active = 1'b1;
            default:  clearing    = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;
    // The result register is free or being emptied this cycle.
    assign fire   = exec_active && (!m_valid_reg || m_ready);

    // Execute stage: the RAM read data belongs to the held request and stays
    // put until the next request is accepted, so a stall on the result side
    // simply waits here.
    assign bit_mask = WORD_BITS'(1) << bit_lo_reg;
    assign is_set   = bm_rd_data[bit_lo_reg];

    always_comb begin
        changed = 1'b0;
        if (!oor_reg) begin
            case (cmd_reg)
                CMD_SET:   changed = !is_set;
                CMD_CLEAR: changed = is_set;
                default:   changed = 1'b0;
            endcase
        end
    end

    // A page is queued at most once, so the fill check never actually blocks.
    assign enqueue = changed && !mk_rd_data[0] && (fill_reg < FILL_MAX);
    assign pop_ok  = (cmd_reg == CMD_POP) && (fill_reg != '0);

    // RAM write ports: the reset sweep owns them until it finishes.
    always_comb begin
        if (clearing) begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = clr_idx_reg;
            bm_wr_data = '0;
            mk_wr_en   = (32'(clr_idx_reg) < 32'(NUM_PAGES));
            mk_wr_addr = clr_idx_reg[PAGE_W-1:0];
            mk_wr_data = 1'b0;
        end else begin
            bm_wr_en   = fire && changed;
            bm_wr_addr = word_addr_reg;
            bm_wr_data = bm_rd_data ^ bit_mask;
            mk_wr_en   = fire && (enqueue || pop_ok);
            mk_wr_addr = enqueue ? page_reg : fq_rd_data;
            mk_wr_data = enqueue;
        end
    end

    assign fq_wr_en = fire && enqueue;

    dbpq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT),
        .AW    (WORD_AW)
    ) u_bitmap_ram (
        .aclk    (aclk),
        .wr_en   (bm_wr_en),
        .wr_addr (bm_wr_addr),
        .wr_data (bm_wr_data),
        .rd_en   (accept),
        .rd_addr (idx_word[WORD_AW-1:0]),
        .rd_data (bm_rd_data)
    );

    dbpq_ram #(
        .WIDTH (1),
        .DEPTH (NUM_PAGES),
        .AW    (PAGE_W)
    ) u_mark_ram (
        .aclk    (aclk),
        .wr_en   (mk_wr_en),
        .wr_addr (mk_wr_addr),
        .wr_data (mk_wr_data),
        .rd_en   (accept),
        .rd_addr (idx_page[PAGE_W-1:0]),
        .rd_data (mk_rd_data)
    );

    // The queue entries need no clearing: the fill count guards every read.
    dbpq_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES),
        .AW    (PAGE_W)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (fq_wr_en),
        .wr_addr (tail_reg),
        .wr_data (page_reg),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (fq_rd_data)
    );

    // Queue pointers, fill and set-bit count.
    always_comb begin
        clr_idx_next = clearing ? clr_idx_reg + WORD_AW'(1) : clr_idx_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        if (fire) begin
            if (enqueue) begin
                tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PAGE_W'(1);
                fill_next = fill_reg + FILL_W'(1);
            end
            if (pop_ok) begin
                head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + PAGE_W'(1);
                fill_next = fill_reg - FILL_W'(1);
            end
            if (changed) begin
                count_next = (cmd_reg == CMD_SET) ? count_reg + LIMIT_W'(1)
                                                  : count_reg - LIMIT_W'(1);
            end
        end
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            count_reg   <= '0;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg       <= s_command;
            oor_reg       <= in_oor;
            word_addr_reg <= idx_word[WORD_AW-1:0];
            bit_lo_reg    <= s_bit_index[WORD_SHIFT-1:0];
            page_reg      <= idx_page[PAGE_W-1:0];
        end
        if (fire) begin
            changed_reg   <= changed;
            oor_out_reg   <= oor_reg && (cmd_reg inside {CMD_SET, CMD_CLEAR});
            pop_valid_reg <= pop_ok;
            popped_reg    <= pop_ok ? POPPED_W'(fq_rd_data) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_changed      = changed_reg;
    assign m_out_of_range = oor_out_reg;
    assign m_pop_valid    = pop_valid_reg;
    assign m_popped_page  = popped_reg;
    assign m_set_count    = count_reg;

    // The queue never holds more than NUM_PAGES entries.
    `DBPQ_ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_MAX)
    // An accepted request always moves on to the execute stage.
    `DBPQ_ASSERT_NEXT(a_accept_exec, aclk, aresetn, accept, state_reg == ST_EXEC)
    // A successful pop removes exactly one queue entry.
    `DBPQ_ASSERT_NEXT(a_pop_drains, aclk, aresetn, fire && pop_ok, fill_reg == $past(fill_reg) - FILL_W'(1))

endmodule

>>> hdl/dbpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dbpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
